### hw/rtl/wheel_encoder_odometer_macros.svh
// Assertion macros for the wheel encoder odometer.
// Included by files that carry concurrent checks; needs no other file.
`ifndef WHEEL_ENCODER_ODOMETER_MACROS_SVH
`define WHEEL_ENCODER_ODOMETER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WEO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WEO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/weo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the wheel encoder odometer.
// Used by weo_regs, weo_ctrl, weo_dp and the top level; depends on nothing.
package weo_pkg;

	localparam int REV_BITS = 32;

	// register indexes on the configuration port
	localparam logic [1:0] REG_PPR     = 2'd0;
	localparam logic [1:0] REG_DPP     = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [15:0] PPR_RESET     = 16'd8;
	localparam logic [31:0] DPP_RESET     = 32'd0;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

	// multiplier operand selects
	localparam logic [1:0] SEL_RP   = 2'd0;
	localparam logic [1:0] SEL_FULL = 2'd1;
	localparam logic [1:0] SEL_REVS = 2'd2;

	typedef struct packed {
		logic [15:0] ppr;
		logic [31:0] dpp;
		logic [31:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic       load_state;
		logic [1:0] mul_sel;
		logic       load_out;
	} cmd_t;

endpackage

### hw/rtl/weo_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the wheel encoder odometer behind an APB-style port.
// Depends on weo_pkg.
module weo_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output weo_pkg::cfg_t cfg
);
	import weo_pkg::*;

	logic [15:0] ppr_q;
	logic [31:0] dpp_q;
	logic [31:0] timeout_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q     <= PPR_RESET;
			dpp_q     <= DPP_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PPR:     ppr_q     <= pwdata[15:0];
				REG_DPP:     dpp_q     <= pwdata;
				REG_TIMEOUT: timeout_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PPR:     prdata = {16'b0, ppr_q};
			REG_DPP:     prdata = dpp_q;
			REG_TIMEOUT: prdata = timeout_q;
			default:     prdata = '0;
		endcase
	end

	assign cfg.ppr     = ppr_q;
	assign cfg.dpp     = dpp_q;
	assign cfg.timeout = timeout_q;

endmodule

### hw/rtl/weo_ctrl.sv
`timescale 1ns / 1ps
// Controller of the wheel encoder odometer: sequences one tick through the
// shared multiplier and owns both handshakes. Depends on weo_pkg.
module weo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output weo_pkg::cmd_t cmd
);
	import weo_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RP   = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_REVS = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd.load_state = 1'b0;
		cmd.mul_sel    = SEL_RP;
		cmd.load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_state = 1'b1;
					state_d        = ST_RP;
				end
			end
			ST_RP: begin
				cmd.mul_sel = SEL_RP;
				state_d     = ST_FULL;
			end
			ST_FULL: begin
				cmd.mul_sel = SEL_FULL;
				state_d     = ST_REVS;
			end
			ST_REVS: begin
				cmd.mul_sel = SEL_REVS;
				// hold here until the output register can take the result
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/weo_dp.sv
`timescale 1ns / 1ps
// Datapath of the wheel encoder odometer: tick state update, one shared
// 32x32 multiplier and the result registers. Depends on weo_pkg.
module weo_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  weo_pkg::cmd_t cmd,
	input  weo_pkg::cfg_t cfg,
	input  logic          pulse,
	output logic [31:0]   total_pulses,
	output logic [47:0]   distance_full,
	output logic [47:0]   distance_revs_only,
	output logic          wheel_stopped
);
	import weo_pkg::*;

	logic [15:0]         pir_q;
	logic [REV_BITS-1:0] rev_q;
	logic [31:0]         ticks_q;
	logic                stopped_q;

	logic [31:0]         ticks_inc;
	logic [16:0]         pir_next;
	logic                wrap;
	logic [15:0]         pir_step;
	logic [REV_BITS-1:0] rev_step;
	logic [31:0]         ticks_step;
	logic                timed_out;
	logic [15:0]         pir_d;
	logic [REV_BITS-1:0] rev_d;
	logic                stopped_d;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] rp_q;
	logic [31:0] total_q;
	logic [47:0] dfull_q;

	logic [31:0] out_total_q;
	logic [47:0] out_full_q;
	logic [47:0] out_revs_q;
	logic        out_stop_q;

	// tick update: count, then pulse and wrap, then timeout
	always_comb begin
		ticks_inc  = (ticks_q == '1) ? ticks_q : ticks_q + 32'd1;
		pir_next   = {1'b0, pir_q} + 17'd1;
		wrap       = pulse && (pir_next >= {1'b0, cfg.ppr});
		pir_step   = !pulse ? pir_q : (wrap ? 16'd0 : pir_next[15:0]);
		rev_step   = wrap ? rev_q + REV_BITS'(1) : rev_q;
		ticks_step = wrap ? 32'd0 : ticks_inc;
		timed_out  = (ticks_step >= cfg.timeout);
		pir_d      = pir_step;
		rev_d      = rev_step;
		stopped_d  = 1'b0;
		if (timed_out) begin
			stopped_d = 1'b1;
			// clear the counts only on entry to the stopped state
			if (!stopped_q) begin
				pir_d = '0;
				rev_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pir_q     <= '0;
			rev_q     <= '0;
			ticks_q   <= '0;
			stopped_q <= 1'b0;
		end else if (cmd.load_state) begin
			pir_q     <= pir_d;
			rev_q     <= rev_d;
			ticks_q   <= ticks_step;
			stopped_q <= stopped_d;
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			SEL_RP: begin
				mul_a = 32'(rev_q);
				mul_b = {16'b0, cfg.ppr};
			end
			SEL_FULL: begin
				mul_a = total_q;
				mul_b = cfg.dpp;
			end
			SEL_REVS: begin
				mul_a = rp_q;
				mul_b = cfg.dpp;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_sel == SEL_RP) begin
			rp_q    <= prod[31:0];
			total_q <= prod[31:0] + {16'b0, pir_q};
		end
		if (cmd.mul_sel == SEL_FULL) begin
			dfull_q <= prod[63:16];
		end
		if (cmd.load_out) begin
			out_total_q <= total_q;
			out_full_q  <= dfull_q;
			out_revs_q  <= prod[63:16];
			out_stop_q  <= stopped_q;
		end
	end

	assign total_pulses       = out_total_q;
	assign distance_full      = out_full_q;
	assign distance_revs_only = out_revs_q;
	assign wheel_stopped      = out_stop_q;

endmodule

### hw/rtl/wheel_encoder_odometer.sv
`timescale 1ns / 1ps
// Wheel encoder odometer. Each input request is one microsecond tick whose
// s_tdata bit 0 flags an encoder pulse; each tick yields one result with the
// total pulse count and two Q32.16 metre distances, with the stopped flag on
// m_tuser. The accepting cycle of a tick updates the counts, then the states
// ST_RP, ST_FULL and ST_REVS pass operands through a single shared 32x32
// multiplier (revolutions times resolution, total times metres per pulse,
// whole-revolution pulses times metres per pulse). The result is loaded into
// the output register in ST_REVS and s_tready returns the cycle after. One
// tick is worked at a time, and a stalled output stretches the last pass
// until that register frees. Configuration goes through the APB-style port
// at addresses 0, 4 and 8.
module wheel_encoder_odometer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [0] pulse, [7:1] zero
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,   // [31:0] total_pulses, [79:32] distance_full,
	                                 // [127:80] distance_revs_only
	output logic [0:0]    m_tuser    // [0] wheel_stopped
);
	import weo_pkg::*;

	`include "wheel_encoder_odometer_macros.svh"

	cfg_t        cfg;
	cmd_t        cmd;
	logic [31:0] total_pulses;
	logic [47:0] distance_full;
	logic [47:0] distance_revs_only;
	logic        wheel_stopped;
	logic        tick_taken;

	weo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	weo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	weo_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.pulse              (s_tdata[0]),
		.total_pulses       (total_pulses),
		.distance_full      (distance_full),
		.distance_revs_only (distance_revs_only),
		.wheel_stopped      (wheel_stopped)
	);

	assign m_tdata    = {distance_revs_only, distance_full, total_pulses};
	assign m_tuser[0] = wheel_stopped;

	assign tick_taken = s_tvalid && s_tready;

	`WEO_ASSERT_NEXT(a_one_tick_at_a_time, clk, arst_n, tick_taken, !s_tready, "tick overlap")
	`WEO_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.load_out, !m_tvalid || m_tready, "result lost")
	`WEO_ASSERT_SAME(a_pass_order, clk, arst_n, tick_taken, ##3 (cmd.mul_sel == SEL_REVS), "pass order")

endmodule
